@@ rtl/core/fsbp_pkg.sv @@
// Shared constants, types and predictor counter function for the fetch stage.
`timescale 1ns / 1ps

package fsbp_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int STORE_DEPTH = 1024;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int WORD_SHIFT  = 2;   // four bytes per instruction word

  localparam int RES_DEPTH = 3;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);

  // two-bit counter states
  localparam logic [1:0] CTR_SNT = 2'd0;
  localparam logic [1:0] CTR_WNT = 2'd1;
  localparam logic [1:0] CTR_ST  = 2'd2;
  localparam logic [1:0] CTR_WT  = 2'd3;

  // instruction classes
  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_JUMP  = 2'd1;
  localparam logic [1:0] CLS_BEQ   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic [1:0]  instr_class;
    logic [15:0] instr_offset;
  } store_word_t;

  typedef struct packed {
    logic [31:0]        fetch_pc;
    logic [1:0]         instr_class;
    logic signed [15:0] instr_offset;
    logic               predicted_taken;
    logic               invalidate;
    logic               insert_bubble;
  } result_t;

  function automatic logic [1:0] ctr_next(input logic [1:0] st, input logic correct);
    logic [1:0] nx;
    nx = st;
    if (correct) begin
      case (st)
        CTR_WT:  nx = CTR_ST;
        CTR_WNT: nx = CTR_SNT;
        default: nx = st;
      endcase
    end else begin
      case (st)
        CTR_SNT: nx = CTR_WNT;
        CTR_WNT: nx = CTR_ST;
        CTR_ST:  nx = CTR_WT;
        default: nx = CTR_SNT;
      endcase
    end
    return nx;
  endfunction

endpackage

@@ rtl/core/fsbp_fetch_if.sv @@
// Request channel: load and fetch-cycle requests into the fetch stage.
`timescale 1ns / 1ps

interface fsbp_fetch_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [9:0]  load_index;
  logic [1:0]  load_class;
  logic signed [15:0] load_offset;
  logic        branch_executed;
  logic        branch_resolved_taken;
  logic        branch_was_predicted;
  logic [31:0] redirect_address;
  logic [31:0] resolved_branch_pc;

  modport source (
    output valid, opcode, load_index, load_class, load_offset, branch_executed,
           branch_resolved_taken, branch_was_predicted, redirect_address,
           resolved_branch_pc,
    input  ready
  );
  modport sink (
    input  valid, opcode, load_index, load_class, load_offset, branch_executed,
           branch_resolved_taken, branch_was_predicted, redirect_address,
           resolved_branch_pc,
    output ready
  );
endinterface

@@ rtl/core/fsbp_result_if.sv @@
// Result channel: one fetched instruction per fetch-cycle request.
`timescale 1ns / 1ps

interface fsbp_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_pc;
  logic [1:0]  instr_class;
  logic signed [15:0] instr_offset;
  logic        predicted_taken;
  logic        invalidate;
  logic        insert_bubble;

  modport source (
    output valid, fetch_pc, instr_class, instr_offset, predicted_taken, invalidate,
           insert_bubble,
    input  ready
  );
  modport sink (
    input  valid, fetch_pc, instr_class, instr_offset, predicted_taken, invalidate,
           insert_bubble,
    output ready
  );
endinterface

@@ rtl/core/fsbp_cfg_if.sv @@
// Configuration write channel carrying the prediction enable.
`timescale 1ns / 1ps

interface fsbp_cfg_if;
  logic valid;
  logic ready;
  logic prediction_enabled;

  modport source (output valid, prediction_enabled, input ready);
  modport sink (input valid, prediction_enabled, output ready);
endinterface

@@ rtl/core/fsbp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module fsbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];   // old data on a same-address write
    end
  end

endmodule

@@ rtl/core/fetch_stage_with_branch_predictor_unit.sv @@
// Fetch stage top level: PC, instruction store, two-bit predictor table, result queue.
`timescale 1ns / 1ps

//  channel    | dir | handshake     | carries
//  fetch_req  | in  | valid/ready   | load or fetch-cycle request with resolved branch info
//  fetch_rsp  | out | valid/ready   | fetched pc, class, offset, prediction, invalidate, bubble
//  cfg        | in  | valid/ready   | prediction_enabled
//
// One request per cycle while fetch_req.ready is high; a fetch result passes through
// stage two and then the result queue. The next fetch address comes from the store
// read data in the same cycle (store RAM output -> adder -> store RAM address).
// Results wait in a three-entry queue; fetch_req.ready drops once the queued results
// plus the one in stage two reach three.
// rst is synchronous: PC to zero, predictor valid bits cleared (entries read as
// strong not taken), prediction off. The instruction store is not cleared.

module fetch_stage_with_branch_predictor_unit (
  input  logic          clk,
  input  logic          rst,
  fsbp_fetch_if.sink    fetch_req,
  fsbp_cfg_if.sink      cfg,
  fsbp_result_if.source fetch_rsp
);

  logic pred_en;

  // current and request PC
  logic [31:0] pc_reg;
  logic [31:0] pc_base;
  logic [31:0] pc_n;
  logic        req_acc;
  logic        fetch_acc;
  logic        load_acc;
  logic        redirect;
  logic        do_train;
  logic        train_ok;
  logic [fsbp_pkg::TABLE_AW-1:0] req_tidx;
  logic [fsbp_pkg::TABLE_AW-1:0] req_pidx;

  // second stage
  logic        s2_v;
  logic [31:0] s2_pc;
  logic        s2_inval;
  logic        s2_train;
  logic        s2_ok;
  logic [fsbp_pkg::TABLE_AW-1:0] s2_tidx;
  logic [fsbp_pkg::TABLE_AW-1:0] s2_pidx;
  logic        s2_a_vld;
  logic        s2_b_vld;
  logic [31:0] s2_next_pc;

  // table write forwarding (write landing at the same edge as the read)
  logic        fwd_v;
  logic [fsbp_pkg::TABLE_AW-1:0] fwd_idx;
  logic [1:0]  fwd_data;

  logic [fsbp_pkg::TABLE_DEPTH-1:0] tbl_vld;
  logic [1:0]  tbl_a_rdata;
  logic [1:0]  tbl_b_rdata;
  logic [1:0]  a_old;
  logic [1:0]  t_new;
  logic [1:0]  b_fwd;
  logic [1:0]  b_val;
  logic        tbl_we;

  fsbp_pkg::store_word_t store_wdata;
  fsbp_pkg::store_word_t store_rdata;
  logic [fsbp_pkg::STORE_AW-1:0] store_waddr;
  logic [fsbp_pkg::STORE_AW-1:0] store_raddr;

  logic [31:0] off_bytes;
  logic        cls_jump;
  logic        cls_beq;
  logic        predict;
  fsbp_pkg::result_t s2_res;

  // result queue
  fsbp_pkg::result_t res_buf [fsbp_pkg::RES_DEPTH];
  logic [fsbp_pkg::RES_AW-1:0] wr_ptr;
  logic [fsbp_pkg::RES_AW-1:0] rd_ptr;
  logic [fsbp_pkg::RES_CW-1:0] res_cnt;
  logic [fsbp_pkg::RES_CW:0]   fill_sum;
  logic        res_push;
  logic        res_pop;

  // ---------------- request side ----------------
  assign fill_sum = {1'b0, res_cnt} + {{fsbp_pkg::RES_CW{1'b0}}, s2_v};
  assign fetch_req.ready = (fill_sum <= (fsbp_pkg::RES_CW + 1)'(fsbp_pkg::RES_DEPTH - 1));
  assign req_acc   = fetch_req.valid && fetch_req.ready;
  assign fetch_acc = req_acc && (fetch_req.opcode == fsbp_pkg::OP_FETCH);
  assign load_acc  = req_acc && (fetch_req.opcode == fsbp_pkg::OP_LOAD);

  assign cfg.ready = 1'b1;

  assign pc_base = s2_v ? s2_next_pc : pc_reg;

  always_comb begin
    if (pred_en) begin
      redirect = fetch_req.branch_executed &&
                 (fetch_req.branch_was_predicted != fetch_req.branch_resolved_taken);
      do_train = fetch_req.branch_executed;
    end else begin
      redirect = fetch_req.branch_resolved_taken;
      do_train = 1'b0;
    end
  end

  assign train_ok = (fetch_req.branch_was_predicted == fetch_req.branch_resolved_taken);
  assign pc_n     = redirect ? fetch_req.redirect_address : pc_base;
  assign req_tidx = fetch_req.resolved_branch_pc[fsbp_pkg::TABLE_AW-1:0];
  assign req_pidx = pc_n[fsbp_pkg::TABLE_AW-1:0];

  assign store_waddr = fetch_req.load_index[fsbp_pkg::STORE_AW-1:0];
  assign store_wdata = '{instr_class: fetch_req.load_class,
                         instr_offset: fetch_req.load_offset};
  assign store_raddr =
    pc_n[fsbp_pkg::STORE_AW+fsbp_pkg::WORD_SHIFT-1:fsbp_pkg::WORD_SHIFT];

  fsbp_ram #(
    .WIDTH ($bits(fsbp_pkg::store_word_t)),
    .DEPTH (fsbp_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (load_acc),
    .waddr (store_waddr),
    .wdata (store_wdata),
    .re    (fetch_acc),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  // predictor table kept as two copies: one read for training, one for prediction
  fsbp_ram #(
    .WIDTH (2),
    .DEPTH (fsbp_pkg::TABLE_DEPTH)
  ) u_tbl_train (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (s2_tidx),
    .wdata (t_new),
    .re    (fetch_acc),
    .raddr (req_tidx),
    .rdata (tbl_a_rdata)
  );

  fsbp_ram #(
    .WIDTH (2),
    .DEPTH (fsbp_pkg::TABLE_DEPTH)
  ) u_tbl_pred (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (s2_tidx),
    .wdata (t_new),
    .re    (fetch_acc),
    .raddr (req_pidx),
    .rdata (tbl_b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_en <= 1'b0;
      pc_reg  <= '0;
      s2_v    <= 1'b0;
      fwd_v   <= 1'b0;
      tbl_vld <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        pred_en <= cfg.prediction_enabled;
      end
      pc_reg <= pc_base;
      s2_v   <= fetch_acc;
      fwd_v  <= tbl_we;
      if (tbl_we) begin
        tbl_vld[s2_tidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx  <= s2_tidx;
    fwd_data <= t_new;
    if (fetch_acc) begin
      s2_pc    <= pc_n;
      s2_inval <= redirect && pred_en;
      s2_train <= do_train;
      s2_ok    <= train_ok;
      s2_tidx  <= req_tidx;
      s2_pidx  <= req_pidx;
      s2_a_vld <= tbl_vld[req_tidx];
      s2_b_vld <= tbl_vld[req_pidx];
    end
  end

  // ---------------- second stage ----------------
  always_comb begin
    a_old = s2_a_vld ? tbl_a_rdata : fsbp_pkg::CTR_SNT;
    if (fwd_v && (fwd_idx == s2_tidx)) begin
      a_old = fwd_data;
    end
    t_new = fsbp_pkg::ctr_next(a_old, s2_ok);

    b_fwd = s2_b_vld ? tbl_b_rdata : fsbp_pkg::CTR_SNT;
    if (fwd_v && (fwd_idx == s2_pidx)) begin
      b_fwd = fwd_data;
    end
    // this request's own training applies before its prediction
    b_val = (s2_train && (s2_tidx == s2_pidx)) ? t_new : b_fwd;
  end

  assign tbl_we = s2_v && s2_train;

  assign cls_jump  = (store_rdata.instr_class == fsbp_pkg::CLS_JUMP);
  assign cls_beq   = (store_rdata.instr_class == fsbp_pkg::CLS_BEQ);
  assign predict   = cls_beq && pred_en && b_val[1];
  assign off_bytes = {{14{store_rdata.instr_offset[15]}}, store_rdata.instr_offset, 2'b00};
  assign s2_next_pc = (cls_jump || predict) ? (s2_pc + off_bytes) : (s2_pc + 32'd4);

  assign s2_res = '{fetch_pc:        s2_pc,
                    instr_class:     store_rdata.instr_class,
                    instr_offset:    store_rdata.instr_offset,
                    predicted_taken: predict,
                    invalidate:      s2_inval,
                    insert_bubble:   cls_beq && !pred_en};

  // ---------------- result queue ----------------
  assign res_push = s2_v;
  assign res_pop  = fetch_rsp.valid && fetch_rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      res_cnt <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= (wr_ptr == fsbp_pkg::RES_AW'(fsbp_pkg::RES_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (res_pop) begin
        rd_ptr <= (rd_ptr == fsbp_pkg::RES_AW'(fsbp_pkg::RES_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      res_cnt <= res_cnt + {{(fsbp_pkg::RES_CW-1){1'b0}}, res_push}
                         - {{(fsbp_pkg::RES_CW-1){1'b0}}, res_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_buf[wr_ptr] <= s2_res;
    end
  end

  assign fetch_rsp.valid           = (res_cnt != '0);
  assign fetch_rsp.fetch_pc        = res_buf[rd_ptr].fetch_pc;
  assign fetch_rsp.instr_class     = res_buf[rd_ptr].instr_class;
  assign fetch_rsp.instr_offset    = res_buf[rd_ptr].instr_offset;
  assign fetch_rsp.predicted_taken = res_buf[rd_ptr].predicted_taken;
  assign fetch_rsp.invalidate      = res_buf[rd_ptr].invalidate;
  assign fetch_rsp.insert_bubble   = res_buf[rd_ptr].insert_bubble;

  // ---------------- assertions ----------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= fsbp_pkg::RES_CW'(fsbp_pkg::RES_DEPTH))
    else $error("result queue overflow");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    fetch_acc |=> (res_cnt != fsbp_pkg::RES_CW'(fsbp_pkg::RES_DEPTH)) || res_pop)
    else $error("fetch accepted with no room for its result");

  a_train_needs_pred: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> pred_en)
    else $error("predictor trained while prediction is off");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    s2_v |-> !(s2_res.insert_bubble && (s2_res.invalidate || s2_res.predicted_taken)))
    else $error("bubble flagged together with predictor activity");

  a_pc_follows: assert property (@(posedge clk) disable iff (rst)
    s2_v && !fetch_acc |=> pc_reg == $past(s2_next_pc))
    else $error("PC lost the next fetch address");

endmodule

@@ bench/fsbp_fetch_checker.sv @@
// Fetch stage scoreboard: tracks PC, store and predictor table, checks every result.
`timescale 1ns / 1ps

module fsbp_fetch_checker
  import fsbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  fsbp_fetch_if       req,
  fsbp_cfg_if         cfg,
  fsbp_result_if      rsp,
  output int          fail_count,
  output int unsigned outstanding
);

  logic        pred_on;
  logic [31:0] pc_q;
  logic [1:0]  ctr_tbl [TABLE_DEPTH];
  store_word_t store_mem [STORE_DEPTH];
  result_t     expected_fetches [$];

  // resolve the executed branch, then fetch at the PC and advance it
  function automatic result_t fetch_step();
    result_t             r;
    store_word_t         w;
    logic [31:0]         branch_target;
    logic [TABLE_AW-1:0] slot;
    r = '0;
    if (pred_on) begin
      if (req.branch_executed) begin
        slot = req.resolved_branch_pc[TABLE_AW-1:0];
        if (req.branch_was_predicted != req.branch_resolved_taken) begin
          pc_q = req.redirect_address;
          r.invalidate = 1'b1;
          // mispredict walks the ring SNT -> WNT -> ST -> WT -> SNT
          ctr_tbl[slot] = ctr_tbl[slot] + 2'd1;
        end else begin
          // correct: settle on the strong state of the same side
          ctr_tbl[slot] = {ctr_tbl[slot][1], 1'b0};
        end
      end
    end else if (req.branch_resolved_taken) begin
      pc_q = req.redirect_address;
    end
    w = store_mem[pc_q[STORE_AW+WORD_SHIFT-1:WORD_SHIFT]];
    branch_target = pc_q + ({{16{w.instr_offset[15]}}, w.instr_offset} << WORD_SHIFT);
    r.fetch_pc     = pc_q;
    r.instr_class  = w.instr_class;
    r.instr_offset = w.instr_offset;
    if (w.instr_class == CLS_JUMP) begin
      pc_q = branch_target;
    end else if (w.instr_class == CLS_BEQ && pred_on && ctr_tbl[pc_q[TABLE_AW-1:0]][1]) begin
      r.predicted_taken = 1'b1;
      pc_q = branch_target;
    end else begin
      r.insert_bubble = (w.instr_class == CLS_BEQ) && !pred_on;
      pc_q = pc_q + 32'd4;
    end
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (rst) begin
      pred_on = 1'b0;
      pc_q    = '0;
      foreach (ctr_tbl[i]) ctr_tbl[i] = CTR_SNT;
      expected_fetches.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_fetches.size() == 0) begin
          $error("unexpected fetch result at pc %h", rsp.fetch_pc);
          fail_count++;
        end else begin
          want = expected_fetches.pop_front();
          if (rsp.fetch_pc !== want.fetch_pc) begin
            $error("fetch_pc: expected %h, actual %h", want.fetch_pc, rsp.fetch_pc);
            fail_count++;
          end
          if (rsp.instr_class !== want.instr_class) begin
            $error("instr_class: expected %0d, actual %0d", want.instr_class, rsp.instr_class);
            fail_count++;
          end
          if (rsp.instr_offset !== want.instr_offset) begin
            $error("instr_offset: expected %0d, actual %0d", want.instr_offset,
                   rsp.instr_offset);
            fail_count++;
          end
          if (rsp.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %b, actual %b", want.predicted_taken,
                   rsp.predicted_taken);
            fail_count++;
          end
          if (rsp.invalidate !== want.invalidate) begin
            $error("invalidate: expected %b, actual %b", want.invalidate, rsp.invalidate);
            fail_count++;
          end
          if (rsp.insert_bubble !== want.insert_bubble) begin
            $error("insert_bubble: expected %b, actual %b", want.insert_bubble,
                   rsp.insert_bubble);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) pred_on = cfg.prediction_enabled;
      if (req.valid && req.ready) begin
        if (req.opcode == OP_LOAD) begin
          store_mem[req.load_index] = {req.load_class, req.load_offset};
        end else begin
          expected_fetches.push_back(fetch_step());
        end
      end
    end
    outstanding = expected_fetches.size();
  end

endmodule

@@ bench/tb_fetch_stage_with_branch_predictor_unit.sv @@
// Fetch stage testbench top: clock, reset, request and config stimulus, verdict.
`timescale 1ns / 1ps

module tb_fetch_stage_with_branch_predictor_unit;
  import fsbp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic               op;
    logic [9:0]         idx;
    logic [1:0]         cls;
    logic signed [15:0] off;
    logic               exec;
    logic               taken;
    logic               was_pred;
    logic [31:0]        redirect;
    logic [31:0]        bpc;
  } fetch_request_t;

  typedef struct {
    logic [31:0]        pc;
    logic signed [15:0] off;
    logic               pred;
  } fetched_branch_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        no_idle;
  int          fail_count;
  int unsigned outstanding;
  int          stalled_cycles;
  fetched_branch_t recent_branches [$];

  fsbp_fetch_if  fetch_req ();
  fsbp_cfg_if    cfg ();
  fsbp_result_if fetch_rsp ();

  always #5 clk = ~clk;

  fetch_stage_with_branch_predictor_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .fetch_req (fetch_req),
    .cfg       (cfg),
    .fetch_rsp (fetch_rsp)
  );

  fsbp_fetch_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (fetch_req),
    .cfg         (cfg),
    .rsp         (fetch_rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] random_class();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return CLS_OTHER;
    if (roll < 60) return CLS_JUMP;
    if (roll < 95) return CLS_BEQ;
    return 2'd3;  // undefined class, fetched like other
  endfunction

  function automatic logic signed [15:0] random_offset();
    logic signed [15:0] v;
    if ($urandom_range(0, 9) < 7) begin
      v = 16'($urandom_range(0, 16));
      v = v - 16'sd8;
    end else begin
      v = 16'($urandom_range(0, 65535));
    end
    return v;
  endfunction

  // mostly resolves a branch seen on the result side with a consistent target;
  // the rest is loads and fetch cycles with noise in the branch fields
  function automatic fetch_request_t random_request();
    fetch_request_t  r;
    fetched_branch_t b;
    int              roll;
    r.op       = OP_FETCH;
    r.idx      = 10'($urandom_range(0, 1023));
    r.cls      = random_class();
    r.off      = random_offset();
    r.exec     = 1'($urandom_range(0, 1));
    r.taken    = ($urandom_range(0, 3) == 0);
    r.was_pred = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 75) r.redirect = {20'd0, 10'($urandom_range(0, 1023)), 2'b00};
    else if (roll < 90) r.redirect = $urandom() & 32'hFFFF_FFFC;
    else r.redirect = $urandom();
    if ($urandom_range(0, 9) < 7) r.bpc = {26'd0, 4'($urandom_range(0, 15)), 2'b00};
    else r.bpc = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      r.op = OP_LOAD;
    end else if (roll < 70 && recent_branches.size() > 0) begin
      b = recent_branches.pop_front();
      r.exec     = 1'b1;
      r.bpc      = b.pc;
      r.was_pred = b.pred;
      r.taken    = 1'($urandom_range(0, 1));
      r.redirect = r.taken ? b.pc + ({{16{b.off[15]}}, b.off} << WORD_SHIFT) : b.pc + 32'd4;
    end
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high if the next request follows
  task automatic send_request(input fetch_request_t r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      fetch_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    fetch_req.opcode                = r.op;
    fetch_req.load_index            = r.idx;
    fetch_req.load_class            = r.cls;
    fetch_req.load_offset           = r.off;
    fetch_req.branch_executed       = r.exec;
    fetch_req.branch_resolved_taken = r.taken;
    fetch_req.branch_was_predicted  = r.was_pred;
    fetch_req.redirect_address      = r.redirect;
    fetch_req.resolved_branch_pc    = r.bpc;
    fetch_req.valid                 = 1'b1;
    @(posedge clk);
    while (!fetch_req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue_load(input logic [9:0] idx, input logic [1:0] cls,
                            input logic signed [15:0] off);
    fetch_request_t r;
    r = '{op: OP_LOAD, idx: idx, cls: cls, off: off, exec: 1'b0, taken: 1'b0,
          was_pred: 1'b0, redirect: 32'd0, bpc: 32'd0};
    send_request(r);
  endtask

  task automatic issue_fetch(input logic exec, input logic taken, input logic was_pred,
                             input logic [31:0] redirect, input logic [31:0] bpc);
    fetch_request_t r;
    r = '{op: OP_FETCH, idx: 10'd0, cls: CLS_OTHER, off: 16'sd0, exec: exec, taken: taken,
          was_pred: was_pred, redirect: redirect, bpc: bpc};
    send_request(r);
  endtask

  task automatic drain();
    fetch_req.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_prediction_enable(input logic on);
    drain();
    repeat (4) @(negedge clk);  // a trailing load may still be in flight
    cfg.prediction_enabled = on;
    cfg.valid = 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // conditional branches seen on the result side, resolved later by the stimulus
  always @(posedge clk) begin
    if (fetch_rsp.valid && fetch_rsp.ready && fetch_rsp.instr_class == CLS_BEQ) begin
      recent_branches.push_back('{pc: fetch_rsp.fetch_pc, off: fetch_rsp.instr_offset,
                                  pred: fetch_rsp.predicted_taken});
      if (recent_branches.size() > 8) void'(recent_branches.pop_front());
    end
  end

  always @(posedge clk) begin
    if ((fetch_req.valid && fetch_req.ready) || (fetch_rsp.valid && fetch_rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
    if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    fetch_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        fetch_rsp.ready = 1'b0;
        stall--;
      end else begin
        fetch_rsp.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    rst     = 1'b1;
    no_idle = 1'b1;
    fetch_req.valid                 = 1'b0;
    fetch_req.opcode                = OP_LOAD;
    fetch_req.load_index            = '0;
    fetch_req.load_class            = CLS_OTHER;
    fetch_req.load_offset           = '0;
    fetch_req.branch_executed       = 1'b0;
    fetch_req.branch_resolved_taken = 1'b0;
    fetch_req.branch_was_predicted  = 1'b0;
    fetch_req.redirect_address      = '0;
    fetch_req.resolved_branch_pc    = '0;
    cfg.valid              = 1'b0;
    cfg.prediction_enabled = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the whole store so no fetch can hit an unwritten word
    for (int i = 0; i < STORE_DEPTH; i++) issue_load(10'(i), random_class(), random_offset());
    no_idle = 1'b0;

    // prediction off: wrapping jumps, bubble, undefined class, unaligned redirect
    issue_load(10'd1023, CLS_JUMP, -16'sd32768);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'h0000_0FFC, 32'd0);
    issue_fetch(1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
    issue_load(10'd0, CLS_BEQ, 16'sd32767);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'd0, 32'd0);
    issue_load(10'd5, 2'd3, 16'sh1234);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'd20, 32'd0);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0);
    issue_fetch(1'b1, 1'b0, 1'b1, 32'h0000_0040, 32'hFFFF_FFFF);

    // prediction on: walk entry 0 around all four counter states
    write_prediction_enable(1'b1);
    issue_load(10'd16, CLS_BEQ, 16'sd16);
    issue_fetch(1'b1, 1'b1, 1'b0, 32'd64, 32'd0);
    issue_fetch(1'b1, 1'b1, 1'b0, 32'd64, 32'd0);
    issue_fetch(1'b1, 1'b1, 1'b1, 32'd0, 32'd0);
    issue_fetch(1'b1, 1'b0, 1'b1, 32'd64, 32'd0);
    issue_fetch(1'b1, 1'b0, 1'b1, 32'd64, 32'd0);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFC, 32'd0);
    issue_fetch(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    issue_fetch(1'b1, 1'b0, 1'b0, 32'd0, 32'd63);

    write_prediction_enable(1'b0);
    issue_fetch(1'b0, 1'b1, 1'b0, 32'd64, 32'd0);

    for (int phase = 0; phase < 6; phase++) begin
      write_prediction_enable(phase % 3 != 1);
      no_idle = (phase == 2);
      for (int n = 0; n < 100; n++) begin
        if (phase == 3 && n == 50) drain();
        send_request(random_request());
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
